[src/string_order_factor_macros.svh]
// Assertion macros shared by the checker files of the string order factor block.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
`ifndef STRING_ORDER_FACTOR_MACROS_SVH
`define STRING_ORDER_FACTOR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SOF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sof_pkg.sv]
// Shared types and constants of the string order factor block.
// Used by every RTL module of the block; depends on nothing.
package sof_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int FACTOR_W        = 32;
    localparam int SUM_W           = 20;
    localparam int NUM_CAPS        = 6;
    localparam int CAP_BASE        = 32;
    // Length class saturates here: strings of 32768 bytes and more share a class.
    localparam int A_MAX           = 15;
    localparam int CAP_A_MIN       = A_MAX - NUM_CAPS + 1;
    localparam int CLASS_LSB       = FACTOR_W - 4;
    // Only the low 4+a bits of the remainder survive the shift into the factor.
    localparam int REM_W           = 4 + A_MAX;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       empty_req;
    } sof_item_t;

    typedef struct packed {
        logic                load;
        logic [FACTOR_W-1:0] factor;
    } sof_res_t;

endpackage

[src/string_order_factor.sv]
// Top level of the string order factor block: input register, core, result register.
// Depends on sof_pkg, sof_in_stage, sof_core and sof_out_stage.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   input   | in_valid / in_ready  | data_byte, last, empty_req
//   output  | out_valid / out_ready| factor
//
// One item per cycle is sustained while no final item waits: each item goes through
// the input register and is folded into the string state by one count update and one
// 20-bit add. A final byte or an empty request loads the result register as the core
// takes it; ordinary bytes give no result. The result register decouples the sides,
// so only a final item that meets a held result waits. Reset clears all string state.
module string_order_factor #(
    parameter int LENGTH_BITS = sof_pkg::LENGTH_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         last,
    input  logic                         empty_req,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sof_pkg::FACTOR_W-1:0] factor
);
    import sof_pkg::*;

    logic      take;
    logic      item_valid;
    sof_item_t item;
    sof_res_t  res;
    logic      out_free;

    sof_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last       (last),
        .empty_req  (empty_req),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sof_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res        (res)
    );

    sof_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .factor    (factor)
    );

endmodule

[src/sof_in_stage.sv]
// Input register of the string order factor block.
// Depends on sof_pkg for the item type.
module sof_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              last,
    input  logic              empty_req,
    input  logic              take,
    output logic              item_valid,
    output sof_pkg::sof_item_t item
);
    import sof_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    sof_item_t item_reg;
    sof_item_t item_next;

    // The register refills in the same cycle that the core takes its item.
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_valid && in_ready)
        begin
            valid_next          = 1'b1;
            item_next.data_byte = data_byte;
            item_next.last      = last;
            item_next.empty_req = empty_req;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

[src/sof_core.sv]
// String state and factor logic of the string order factor block.
// Depends on sof_pkg; feeds the result register in sof_out_stage.
module sof_core #(
    parameter int LENGTH_BITS = sof_pkg::LENGTH_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  sof_pkg::sof_item_t item,
    input  logic               out_free,
    output logic               take,
    output sof_pkg::sof_res_t  res
);
    import sof_pkg::*;

    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    logic [7:0]             first_reg;
    logic [7:0]             first_next;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W-1:0]       caps_reg  [NUM_CAPS];
    logic [SUM_W-1:0]       caps_next [NUM_CAPS];

    logic                   produce;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [7:0]             first_new;
    logic [SUM_W-1:0]       sum_new;
    logic [SUM_W-1:0]       caps_new  [NUM_CAPS];
    logic [63:0]            cnt_ext;
    logic [3:0]             a;
    logic [4:0]             dbits;
    logic [REM_W-1:0]       rem;
    logic [3:0]             cap_sel;
    logic [SUM_W-1:0]       sum_sel;
    logic [FACTOR_W-1:0]    mask;
    logic [FACTOR_W-1:0]    factor_calc;

    assign produce = item.empty_req || item.last;
    assign take    = item_valid && (!produce || out_free);

    // Append the byte: the first byte is kept apart, later ones are summed signed.
    always_comb
    begin
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        if (count_reg == '0)
        begin
            first_new = item.data_byte;
            sum_new   = sum_reg;
        end
        else
        begin
            first_new = first_reg;
            sum_new   = sum_reg + {{(SUM_W-8){item.data_byte[7]}}, item.data_byte};
        end
        for (int k = 0; k < NUM_CAPS; k++)
        begin
            caps_new[k] = (count_inc == LENGTH_BITS'(CAP_BASE << k)) ? sum_new : caps_reg[k];
        end
    end

    // Length class and packing of the factor from the updated string state.
    always_comb
    begin
        cnt_ext = 64'(count_inc);
        a       = '0;
        for (int i = 0; i < A_MAX; i++)
        begin
            if (cnt_ext[i])
            begin
                a = 4'(i);
            end
        end
        if (|cnt_ext[63:A_MAX])
        begin
            a = 4'(A_MAX);
        end
        dbits   = 5'(SUM_W) - {1'b0, a};
        rem     = cnt_ext[REM_W-1:0] - (REM_W'(1) << a);
        cap_sel = 4'(A_MAX) - a;
        if (a >= 4'(CAP_A_MIN))
        begin
            sum_sel = caps_new[cap_sel[2:0]];
        end
        else
        begin
            sum_sel = sum_new;
        end
        mask        = (FACTOR_W'(1) << dbits) - FACTOR_W'(1);
        factor_calc = ((FACTOR_W'(a) + FACTOR_W'(1)) << CLASS_LSB)
                    | (FACTOR_W'(rem) << (5'(CLASS_LSB) - {1'b0, a}))
                    | (FACTOR_W'(first_new) << dbits)
                    | (FACTOR_W'(sum_sel) & mask);
    end

    always_comb
    begin
        res.load   = take && produce;
        res.factor = item.empty_req ? '0 : factor_calc;
    end

    always_comb
    begin
        count_next = count_reg;
        first_next = first_reg;
        sum_next   = sum_reg;
        caps_next  = caps_reg;
        if (take)
        begin
            if (produce)
            begin
                count_next = '0;
                first_next = '0;
                sum_next   = '0;
                for (int k = 0; k < NUM_CAPS; k++)
                begin
                    caps_next[k] = '0;
                end
            end
            else
            begin
                count_next = count_inc;
                first_next = first_new;
                sum_next   = sum_new;
                caps_next  = caps_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            first_reg <= '0;
            sum_reg   <= '0;
            for (int k = 0; k < NUM_CAPS; k++)
            begin
                caps_reg[k] <= '0;
            end
        end
        else
        begin
            count_reg <= count_next;
            first_reg <= first_next;
            sum_reg   <= sum_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

[src/sof_out_stage.sv]
// Result register of the string order factor block.
// Depends on sof_pkg for the result type.
module sof_out_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sof_pkg::sof_res_t              res,
    output logic                           out_free,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sof_pkg::FACTOR_W-1:0]   factor
);
    import sof_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [FACTOR_W-1:0] factor_reg;
    logic [FACTOR_W-1:0] factor_next;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign factor    = factor_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        factor_next = factor_reg;
        if (res.load)
        begin
            valid_next  = 1'b1;
            factor_next = res.factor;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        factor_reg <= factor_next;
    end

endmodule

[src/sof_checker.sv]
// Port-level checks of the string order factor block, bound to the top level.
// Depends on string_order_factor_macros.svh.
`include "string_order_factor_macros.svh"

module sof_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  data_byte,
    input logic        last,
    input logic        empty_req,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] factor
);

    // A held result must not change or vanish before it is taken.
    `SOF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(factor), "result changed while stalled")

    // With the result register empty, nothing may block the input side.
    `SOF_ASSERT_IMPL(a_in_open, !out_valid, in_ready, "input stalled with no result pending")

    // A one-byte string has no remainder and no byte sum.
    `SOF_ASSERT_IMPL(a_len_one, out_valid && factor[31:28] == 4'd1, factor[19:0] == 20'd0, "one-byte factor has low bits set")

endmodule

bind string_order_factor sof_checker u_sof_checker (.*);
